### src/page_permission_table_core_macros.svh
// assertion macros for the page permission table
// no dependencies; included by the checker
`ifndef PAGE_PERMISSION_TABLE_CORE_MACROS_SVH
`define PAGE_PERMISSION_TABLE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define PPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppt assertion failed");

// next-cycle implication, clocked on clk, disabled in reset
`define PPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppt assertion failed");

`endif

### src/ppt_pkg.sv
// shared constants and helpers for the page permission table
// no dependencies
package ppt_pkg;

    localparam int PAGE_BITS_DEF = 12;
    localparam int NUM_PAGES_DEF = 1024;

    localparam logic [2:0] OP_MAP    = 3'd0;
    localparam logic [2:0] OP_UNMAP  = 3'd1;
    localparam logic [2:0] OP_REPROT = 3'd2;
    localparam logic [2:0] OP_CHECK  = 3'd3;
    localparam logic [2:0] OP_PROBE  = 3'd4;

    localparam logic [1:0] KIND_FETCH = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam int PERM_R_BIT = 0;
    localparam int PERM_W_BIT = 1;
    localparam int PERM_X_BIT = 2;

    function automatic logic kind_permitted(input logic [2:0] perm, input logic [1:0] kind);
        logic res;
        case (kind)
            KIND_FETCH: res = perm[PERM_X_BIT];
            KIND_READ:  res = |perm;
            KIND_WRITE: res = perm[PERM_W_BIT];
            default:    res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

### src/ppt_req_if.sv
// request channel: valid/ready handshake with the request payload
// no dependencies
interface ppt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [63:0] address;
    logic [31:0] span_bytes;
    logic [2:0]  perms;
    logic [1:0]  access_kind;

    modport source (output valid, op, address, span_bytes, perms, access_kind, input ready);
    modport sink (input valid, op, address, span_bytes, perms, access_kind, output ready);
endinterface

### src/ppt_rsp_if.sv
// response channel: valid/ready handshake with the result payload
// no dependencies
interface ppt_rsp_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic [63:0] epoch_now;

    modport source (output valid, allowed, epoch_now, input ready);
    modport sink (input valid, allowed, epoch_now, output ready);
endinterface

### src/page_permission_table_core.sv
// page permission table top level: sequencer around the entry memories
// depends on ppt_pkg, ppt_req_if, ppt_rsp_if
// S_SET1, S_SET2 set up; S_ISSUE, S_EVAL per page visited (twice for a write check); S_DONE to output
// one transaction at a time: req.ready is high only in idle, and S_DONE waits out an output stall
// the walk is paced by the registered read of the valid/permission memory per page
// reset: epoch counter cleared, then a clearing pass over all NUM_PAGES entries of the
// valid/permission memory with req.ready low; epoch memory is not cleared
module page_permission_table_core #(
    parameter int PAGE_BITS = ppt_pkg::PAGE_BITS_DEF,
    parameter int NUM_PAGES = ppt_pkg::NUM_PAGES_DEF
) (
    input logic      clk,
    input logic      rst_n,
    ppt_req_if.sink   req,
    ppt_rsp_if.source rsp
);
    import ppt_pkg::*;

    localparam int PW = $clog2(NUM_PAGES);
    localparam logic [63:0] NUM64 = 64'(NUM_PAGES);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SET1  = 3'd2;
    localparam logic [2:0] S_SET2  = 3'd3;
    localparam logic [2:0] S_ISSUE = 3'd4;
    localparam logic [2:0] S_EVAL  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // entry memories: {valid, perm} and the code epoch
    logic [3:0]  vp_mem [NUM_PAGES];
    logic [63:0] ep_mem [NUM_PAGES];
    logic [3:0]  vp_rd_reg;

    logic [2:0]  state_reg, state_next;
    logic [PW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [2:0]  op_reg, op_next;
    logic [63:0] addr_reg, addr_next;
    logic [31:0] len_reg, len_next;
    logic [2:0]  perms_reg, perms_next;
    logic [1:0]  kind_reg, kind_next;
    logic [64:0] sum_end_reg, sum_end_next;
    logic [64:0] sum_last_reg, sum_last_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] first_reg, first_next;
    logic [PW-1:0] last_reg, last_next;
    logic        pass_reg, pass_next;
    logic        ok_reg, ok_next;
    logic [63:0] epoch_reg, epoch_next;
    logic        out_vld_reg, out_vld_next;
    logic        out_allowed_reg, out_allowed_next;
    logic [63:0] out_epoch_reg, out_epoch_next;

    logic        vp_we;
    logic [PW-1:0] vp_wa;
    logic [3:0]  vp_wd;
    logic        ep_we;

    // range bounds worked out in S_SET2
    logic        len_zero;
    logic [63:0] first64, ep_raw, endc, lastp;
    logic        range_bad;

    logic        pg_valid;
    logic [2:0]  pg_perm;
    logic        adv, fin;

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_vld_reg;
    assign rsp.allowed   = out_allowed_reg;
    assign rsp.epoch_now = out_epoch_reg;

    assign len_zero = (len_reg == 32'd0);
    assign first64  = addr_reg >> PAGE_BITS;
    assign ep_raw   = (sum_end_reg[63:0] >> PAGE_BITS)
                    + {63'd0, |sum_end_reg[PAGE_BITS-1:0]};
    // saturate on carry out of the address space, then clip to the table
    assign endc     = (sum_end_reg[64] || (ep_raw > NUM64)) ? NUM64 : ep_raw;
    assign lastp    = len_zero ? first64 : (sum_last_reg[63:0] >> PAGE_BITS);
    assign range_bad = (!len_zero && sum_last_reg[64]) || (lastp >= NUM64);

    assign pg_valid = vp_rd_reg[3];
    assign pg_perm  = vp_rd_reg[2:0];

    always_ff @(posedge clk)
    begin
        if (vp_we)
        begin
            vp_mem[vp_wa] <= vp_wd;
        end
        if (ep_we)
        begin
            ep_mem[cur_reg] <= epoch_next;
        end
        vp_rd_reg <= vp_mem[cur_reg];
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        op_next          = op_reg;
        addr_next        = addr_reg;
        len_next         = len_reg;
        perms_next       = perms_reg;
        kind_next        = kind_reg;
        sum_end_next     = sum_end_reg;
        sum_last_next    = sum_last_reg;
        cur_next         = cur_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        pass_next        = pass_reg;
        ok_next          = ok_reg;
        epoch_next       = epoch_reg;
        out_vld_next     = out_vld_reg;
        out_allowed_next = out_allowed_reg;
        out_epoch_next   = out_epoch_reg;
        vp_we            = 1'b0;
        vp_wa            = cur_reg;
        vp_wd            = 4'd0;
        ep_we            = 1'b0;
        adv              = 1'b0;
        fin              = 1'b0;

        if (rsp.valid && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                // clearing pass over the valid/permission memory
                vp_we = 1'b1;
                vp_wa = clr_cnt_reg;
                vp_wd = 4'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PW'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    addr_next  = req.address;
                    len_next   = req.span_bytes;
                    perms_next = req.perms;
                    kind_next  = req.access_kind;
                    state_next = S_SET1;
                end
            end
            S_SET1:
            begin
                sum_end_next  = {1'b0, addr_reg} + {33'd0, len_reg};
                sum_last_next = {1'b0, addr_reg} + {33'd0, len_reg - 32'd1};
                state_next    = S_SET2;
            end
            S_SET2:
            begin
                first_next = first64[PW-1:0];
                cur_next   = first64[PW-1:0];
                pass_next  = 1'b0;
                ok_next    = 1'b1;
                state_next = S_DONE;
                case (op_reg)
                    OP_MAP, OP_UNMAP, OP_REPROT:
                    begin
                        if (!len_zero)
                        begin
                            if (op_reg == OP_UNMAP)
                            begin
                                epoch_next = epoch_reg + 64'd1;
                            end
                            if (first64 < endc)
                            begin
                                last_next  = PW'(endc - 64'd1);
                                state_next = S_ISSUE;
                            end
                        end
                    end
                    OP_CHECK:
                    begin
                        if (range_bad)
                        begin
                            ok_next = 1'b0;
                        end
                        else
                        begin
                            last_next  = lastp[PW-1:0];
                            state_next = S_ISSUE;
                        end
                    end
                    OP_PROBE:
                    begin
                        // an empty probe succeeds without a walk
                        if (!len_zero)
                        begin
                            if (range_bad)
                            begin
                                ok_next = 1'b0;
                            end
                            else
                            begin
                                last_next  = lastp[PW-1:0];
                                state_next = S_ISSUE;
                            end
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            S_ISSUE:
            begin
                // memory read of cur_reg lands in vp_rd_reg next cycle
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                case (op_reg)
                    OP_MAP:
                    begin
                        vp_we      = 1'b1;
                        vp_wd      = {1'b1, perms_reg};
                        epoch_next = epoch_reg + 64'd1;
                        ep_we      = 1'b1;
                        adv        = 1'b1;
                    end
                    OP_UNMAP:
                    begin
                        vp_we = 1'b1;
                        vp_wd = {1'b0, pg_perm};
                        adv   = 1'b1;
                    end
                    OP_REPROT:
                    begin
                        if (pg_valid)
                        begin
                            vp_we      = 1'b1;
                            vp_wd      = {1'b1, perms_reg};
                            epoch_next = epoch_reg + 64'd1;
                            ep_we      = 1'b1;
                        end
                        adv = 1'b1;
                    end
                    OP_CHECK:
                    begin
                        if (!pass_reg)
                        begin
                            if (!pg_valid || !kind_permitted(pg_perm, kind_reg))
                            begin
                                ok_next = 1'b0;
                                fin     = 1'b1;
                            end
                            else
                            begin
                                adv = 1'b1;
                            end
                        end
                        else
                        begin
                            // restamp pass for a permitted data write
                            if (pg_perm[PERM_X_BIT])
                            begin
                                epoch_next = epoch_reg + 64'd1;
                                ep_we      = 1'b1;
                            end
                            adv = 1'b1;
                        end
                    end
                    OP_PROBE:
                    begin
                        if (!pg_valid)
                        begin
                            ok_next = 1'b0;
                            fin     = 1'b1;
                        end
                        else
                        begin
                            adv = 1'b1;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
                if (adv)
                begin
                    if (cur_reg == last_reg)
                    begin
                        if ((op_reg == OP_CHECK) && !pass_reg && (kind_reg == KIND_WRITE))
                        begin
                            pass_next  = 1'b1;
                            cur_next   = first_reg;
                            state_next = S_ISSUE;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    else
                    begin
                        cur_next   = cur_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
                if (fin)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand off once the output register is free
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next     = 1'b1;
                    out_allowed_next = ok_reg;
                    out_epoch_next   = epoch_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            epoch_reg   <= 64'd0;
            out_vld_reg <= 1'b0;
            pass_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            epoch_reg   <= epoch_next;
            out_vld_reg <= out_vld_next;
            pass_reg    <= pass_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        addr_reg        <= addr_next;
        len_reg         <= len_next;
        perms_reg       <= perms_next;
        kind_reg        <= kind_next;
        sum_end_reg     <= sum_end_next;
        sum_last_reg    <= sum_last_next;
        cur_reg         <= cur_next;
        first_reg       <= first_next;
        last_reg        <= last_next;
        ok_reg          <= ok_next;
        out_allowed_reg <= out_allowed_next;
        out_epoch_reg   <= out_epoch_next;
    end

endmodule

### src/ppt_checker.sv
// port-level checks for the page permission table, bound to the top level
// depends on page_permission_table_core_macros.svh
`include "page_permission_table_core_macros.svh"

module ppt_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready
);
    logic rst_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rst_seen_reg <= 1'b0;
        end
        else
        begin
            rst_seen_reg <= 1'b1;
        end
    end

    // a pending result stays offered until taken
    `PPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    // one transaction in flight: no accept right after an accept
    `PPT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
    // the clearing pass keeps the request side closed just after reset
    `PPT_ASSERT_NOW(a_clear_after_reset, !rst_seen_reg, !req_ready)

endmodule

bind page_permission_table_core ppt_checker u_ppt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
);
